[hw/rtl/midi_file_track_event_parser_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the track event parser
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_FILE_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_FILE_TRACK_EVENT_PARSER_UNIT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define MFTP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define MFTP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MFTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mftp_pkg.sv]
// ----------------------------------------------------------------------------
// Track event parser package
// Types, codes and small helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
package mftp_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_DATA1      = 4'd2,
    PH_DATA2      = 4'd3,
    PH_META_TYPE  = 4'd4,
    PH_META_LEN   = 4'd5,
    PH_META_BODY  = 4'd6,
    PH_SYSEX_LEN  = 4'd7,
    PH_SYSEX_BODY = 4'd8
  } phase_e;

  // Result kinds.
  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_CHANNEL     = 3'd1,
    EV_SYSEX_BYTE  = 3'd2,
    EV_SYSEX_EMPTY = 3'd3,
    EV_TEMPO       = 3'd4,
    EV_LOOP_MARK   = 3'd5
  } ev_kind_e;

  // Status and meta codes.
  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_MARKER  = 8'h06;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  // Meta body bookkeeping.
  localparam logic [3:0]  TEMPO_BYTES   = 4'd3;
  localparam logic [3:0]  TEMPO_LAST    = 4'd2;
  localparam logic [3:0]  LOOP_NAME_LEN = 4'd9;
  localparam logic [3:0]  LOOP_LAST     = 4'd8;
  localparam logic [3:0]  META_IDX_MAX  = 4'd15;
  localparam logic [31:0] LOOP_META_LEN = 32'd9;

  // One result beat.
  typedef struct packed {
    ev_kind_e    kind;
    logic [31:0] abs_tick;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [23:0] tempo_value;
    logic [7:0]  sysex_data;
    logic        sysex_last;
    logic        track_end;
  } res_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Program change and channel pressure carry a single data byte.
  function automatic logic one_data_byte(logic [7:0] st);
    return (st[7:4] == HI_PROGRAM) || (st[7:4] == HI_PRESSURE);
  endfunction

  // Characters of the loop start marker text.
  function automatic logic [7:0] loop_char(logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6C;  // l
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h6F;  // o
      4'd3:    ch = 8'h70;  // p
      4'd4:    ch = 8'h53;  // S
      4'd5:    ch = 8'h74;  // t
      4'd6:    ch = 8'h61;  // a
      4'd7:    ch = 8'h72;  // r
      4'd8:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/mftp_if.sv]
// ----------------------------------------------------------------------------
// Track event parser channels
// Valid/ready channels for the input bytes and the result beats.
// ----------------------------------------------------------------------------

// Input byte channel.
interface mftp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       last_of_track;

  modport source (output valid, output track_byte, output last_of_track, input ready);
  modport sink   (input valid, input track_byte, input last_of_track, output ready);
endinterface

// Result channel.
interface mftp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] abs_tick;
  logic [7:0]  status_byte;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [23:0] tempo_value;
  logic [7:0]  sysex_data;
  logic        sysex_last;
  logic        track_end;

  modport source (output valid, output event_kind, output abs_tick, output status_byte,
                  output data_one, output data_two, output tempo_value,
                  output sysex_data, output sysex_last, output track_end, input ready);
  modport sink   (input valid, input event_kind, input abs_tick, input status_byte,
                  input data_one, input data_two, input tempo_value,
                  input sysex_data, input sysex_last, input track_end, output ready);
endinterface

[hw/rtl/midi_file_track_event_parser_unit.sv]
// ----------------------------------------------------------------------------
// MIDI file track event parser
// A result passes through the result queue and then the output register before it is offered.
// Throughput: one byte per cycle while the result queue has room.
// The input stalls only while the QUEUE_DEPTH-entry result queue is full.
// Reset (rst_ni low, asynchronous) clears the parser, queue and output stage.
// ----------------------------------------------------------------------------
module midi_file_track_event_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mftp_in_if.sink    in_i,
  mftp_out_if.source out_o
);

  logic              push;
  logic              pop;
  mftp_pkg::res_t    push_data;
  mftp_pkg::res_t    head;
  mftp_pkg::q_stat_t q_stat;

  // Byte parser.
  mftp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Result queue.
  mftp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (head),
    .stat_o      (q_stat)
  );

  // Output register.
  mftp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

[hw/rtl/mftp_front.sv]
// ----------------------------------------------------------------------------
// Track event parser front end
// Accepts one track byte per beat, runs the byte-wise parser and pushes each
// finished result into the queue.
// ----------------------------------------------------------------------------
`include "midi_file_track_event_parser_unit_macros.svh"

module mftp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  mftp_in_if.sink          in_i,
  input  mftp_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output mftp_pkg::res_t   push_data_o
);

  mftp_pkg::phase_e phase_q, phase_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  run_q, run_d;
  logic [7:0]  cur_q, cur_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  mkind_q, mkind_d;
  logic [3:0]  midx_q, midx_d;
  logic [23:0] tempo_q, tempo_d;
  logic        match_q, match_d;
  logic [7:0]  first_q, first_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [31:0] vlq;
  logic [7:0]  st;
  logic        match_now;
  mftp_pkg::res_t res;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.track_byte;
  assign last       = in_i.last_of_track;
  assign vlq        = {len_q[24:0], b[6:0]};
  assign st         = b[7] ? b : run_q;
  assign match_now  = match_q && (b == mftp_pkg::loop_char(midx_q));

  // Next state and result for the byte on the input.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    run_d    = run_q;
    cur_d    = cur_q;
    len_d    = len_q;
    left_d   = left_q;
    mkind_d  = mkind_q;
    midx_d   = midx_q;
    tempo_d  = tempo_q;
    match_d  = match_q;
    first_d  = first_q;
    halted_d = halted_q;
    res      = '0;
    res.kind = mftp_pkg::EV_NONE;

    if (!halted_q) begin
      case (phase_q)
        mftp_pkg::PH_DELTA: begin
          len_d = vlq;
          if (!b[7]) begin
            tick_d  = tick_q + vlq;
            len_d   = '0;
            phase_d = mftp_pkg::PH_STATUS;
          end
        end
        mftp_pkg::PH_STATUS: begin
          if (!b[7] && !run_q[7]) begin
            halted_d = 1'b1;
          end else if (st == mftp_pkg::STATUS_META) begin
            phase_d = mftp_pkg::PH_META_TYPE;
          end else if (st == mftp_pkg::SYSEX_START || st == mftp_pkg::SYSEX_ESCAPE) begin
            cur_d   = st;
            len_d   = '0;
            phase_d = mftp_pkg::PH_SYSEX_LEN;
          end else begin
            cur_d = st;
            run_d = st;
            if (b[7]) begin
              phase_d = mftp_pkg::PH_DATA1;
            end else if (mftp_pkg::one_data_byte(st)) begin
              // Running status with a single data byte completes at once.
              res.kind        = mftp_pkg::EV_CHANNEL;
              res.status_byte = st;
              res.data_one    = b;
              phase_d         = mftp_pkg::PH_DELTA;
            end else begin
              first_d = b;
              phase_d = mftp_pkg::PH_DATA2;
            end
          end
        end
        mftp_pkg::PH_DATA1: begin
          if (mftp_pkg::one_data_byte(cur_q)) begin
            res.kind        = mftp_pkg::EV_CHANNEL;
            res.status_byte = cur_q;
            res.data_one    = b;
            phase_d         = mftp_pkg::PH_DELTA;
          end else begin
            first_d = b;
            phase_d = mftp_pkg::PH_DATA2;
          end
        end
        mftp_pkg::PH_DATA2: begin
          res.kind        = mftp_pkg::EV_CHANNEL;
          res.status_byte = cur_q;
          res.data_one    = first_q;
          res.data_two    = b;
          phase_d         = mftp_pkg::PH_DELTA;
        end
        mftp_pkg::PH_META_TYPE: begin
          mkind_d = b;
          len_d   = '0;
          phase_d = mftp_pkg::PH_META_LEN;
        end
        mftp_pkg::PH_META_LEN: begin
          len_d = vlq;
          if (!b[7]) begin
            run_d   = '0;
            left_d  = vlq;
            len_d   = '0;
            midx_d  = '0;
            tempo_d = '0;
            match_d = (vlq == mftp_pkg::LOOP_META_LEN);
            phase_d = (vlq != '0) ? mftp_pkg::PH_META_BODY : mftp_pkg::PH_DELTA;
          end
        end
        mftp_pkg::PH_META_BODY: begin
          if (mkind_q == mftp_pkg::META_TEMPO && midx_q < mftp_pkg::TEMPO_BYTES) begin
            tempo_d = {tempo_q[15:0], b};
            if (midx_q == mftp_pkg::TEMPO_LAST) begin
              res.kind        = mftp_pkg::EV_TEMPO;
              res.tempo_value = {tempo_q[15:0], b};
            end
          end else if (mkind_q == mftp_pkg::META_MARKER &&
                       midx_q < mftp_pkg::LOOP_NAME_LEN) begin
            match_d = match_now;
            if (midx_q == mftp_pkg::LOOP_LAST && match_now) begin
              res.kind = mftp_pkg::EV_LOOP_MARK;
            end
          end
          if (midx_q < mftp_pkg::META_IDX_MAX) begin
            midx_d = midx_q + 4'd1;
          end
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = mftp_pkg::PH_DELTA;
          end
        end
        mftp_pkg::PH_SYSEX_LEN: begin
          len_d = vlq;
          if (!b[7]) begin
            run_d  = '0;
            left_d = vlq;
            len_d  = '0;
            if (cur_q == mftp_pkg::SYSEX_START) begin
              // The start byte itself goes out as the first payload byte.
              res.kind       = mftp_pkg::EV_SYSEX_BYTE;
              res.sysex_data = mftp_pkg::SYSEX_START;
              res.sysex_last = (vlq == '0);
            end else if (vlq == '0) begin
              res.kind = mftp_pkg::EV_SYSEX_EMPTY;
            end
            phase_d = (vlq != '0) ? mftp_pkg::PH_SYSEX_BODY : mftp_pkg::PH_DELTA;
          end
        end
        mftp_pkg::PH_SYSEX_BODY: begin
          res.kind       = mftp_pkg::EV_SYSEX_BYTE;
          res.sysex_data = b;
          res.sysex_last = (left_q == 32'd1);
          left_d         = left_q - 32'd1;
          if (left_q == 32'd1) begin
            phase_d = mftp_pkg::PH_DELTA;
          end
        end
        default: begin
          phase_d = mftp_pkg::PH_DELTA;
        end
      endcase
    end

    res.abs_tick = tick_d;

    // The last byte always reports and returns the parser to its reset state.
    if (last) begin
      res.track_end = 1'b1;
      phase_d  = mftp_pkg::PH_DELTA;
      tick_d   = '0;
      run_d    = '0;
      cur_d    = '0;
      len_d    = '0;
      left_d   = '0;
      mkind_d  = '0;
      midx_d   = '0;
      tempo_d  = '0;
      match_d  = 1'b1;
      first_d  = '0;
      halted_d = 1'b0;
    end
  end

  assign push_o      = accept && (res.kind != mftp_pkg::EV_NONE || last);
  assign push_data_o = res;

  // Parser state, updated on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mftp_pkg::PH_DELTA;
      tick_q   <= '0;
      run_q    <= '0;
      cur_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      mkind_q  <= '0;
      midx_q   <= '0;
      tempo_q  <= '0;
      match_q  <= 1'b1;
      first_q  <= '0;
      halted_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      run_q    <= run_d;
      cur_q    <= cur_d;
      len_q    <= len_d;
      left_q   <= left_d;
      mkind_q  <= mkind_d;
      midx_q   <= midx_d;
      tempo_q  <= tempo_d;
      match_q  <= match_d;
      first_q  <= first_d;
      halted_q <= halted_d;
    end
  end

  // A halted parser stays silent until the track's last byte.
  `MFTP_ASSERT_IMPLY(a_halted_silent, halted_q && !last, !push_o,
                     "halted parser pushed a result")
  // Every accepted last byte leaves a clean parser behind.
  `MFTP_ASSERT_NEXT(a_last_resets, accept && last,
                    phase_q == mftp_pkg::PH_DELTA && tick_q == '0 && !halted_q,
                    "parser state not reset after the last byte")
  // Bytes are only taken while the queue has room.
  `MFTP_ASSERT_IMPLY(a_no_push_full, q_stat_i.full, !push_o,
                     "push into a full queue")

endmodule

[hw/rtl/mftp_queue.sv]
// ----------------------------------------------------------------------------
// Track event parser result queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "midi_file_track_event_parser_unit_macros.svh"

module mftp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mftp_pkg::res_t    push_data_i,
  input  logic              pop_i,
  output mftp_pkg::res_t    pop_data_o,
  output mftp_pkg::q_stat_t stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mftp_pkg::res_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  count_q;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // The fill count never runs past the depth.
  `MFTP_ASSERT_ALWAYS(a_count_range, count_q <= CW'(DEPTH), "queue count out of range")
  // Nothing is popped from an empty queue.
  `MFTP_ASSERT_IMPLY(a_no_pop_empty, stat_o.empty, !pop_i, "pop from an empty queue")

endmodule

[hw/rtl/mftp_back.sv]
// ----------------------------------------------------------------------------
// Track event parser output stage
// Takes result beats from the queue into an output register and offers them
// on the result channel.
// ----------------------------------------------------------------------------
module mftp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mftp_pkg::q_stat_t q_stat_i,
  input  mftp_pkg::res_t    head_i,
  output logic              pop_o,
  mftp_out_if.source        out_o
);

  logic           valid_q;
  mftp_pkg::res_t data_q;

  // Refill the output register whenever it is empty or being taken.
  assign pop_o = !q_stat_i.empty && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= !q_stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  // Result channel drive.
  assign out_o.valid       = valid_q;
  assign out_o.event_kind  = data_q.kind;
  assign out_o.abs_tick    = data_q.abs_tick;
  assign out_o.status_byte = data_q.status_byte;
  assign out_o.data_one    = data_q.data_one;
  assign out_o.data_two    = data_q.data_two;
  assign out_o.tempo_value = data_q.tempo_value;
  assign out_o.sysex_data  = data_q.sysex_data;
  assign out_o.sysex_last  = data_q.sysex_last;
  assign out_o.track_end   = data_q.track_end;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Track event parser testbench
// Streams track-body bytes into the parser under random back-pressure and
// checks every result beat against a byte-wise parser model kept here.
// ----------------------------------------------------------------------------
module tb;

  // One pending input beat: a track byte and its end-of-track flag.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } track_beat_t;

  localparam int unsigned    HOLD_CYCLES = 300;
  localparam int unsigned    TAIL_CYCLES = 8;
  localparam longint         TIMEOUT_NS  = 4_000_000;
  localparam logic [7:0]     ST_NOTE_ON  = 8'h90;
  localparam logic [7:0]     CHAN_LO     = 8'h80;
  localparam logic [7:0]     CHAN_HI     = 8'hEF;
  localparam logic [7:0]     SYS_LO      = 8'hF1;
  localparam logic [7:0]     SYS_HI      = 8'hFE;
  localparam logic [7:0]     DATA_MAX    = 8'h7F;
  localparam logic [8*9-1:0] LOOP_TEXT   = "loopStart";

  // Directed tracks: channel extremes, running status, zero tempo, zero-length
  // SysEx of both kinds, a stray data byte that halts the track, and a SysEx
  // cut short by the end of the track.
  localparam int DIR_A_LEN = 23;
  localparam logic [8*DIR_A_LEN-1:0] DIR_A = {
    8'h00, ST_NOTE_ON, 8'h00, 8'h7F,
    8'h00, 8'h7F, 8'h00,
    8'h00, mftp_pkg::STATUS_META, mftp_pkg::META_TEMPO, 8'h03, 8'h00, 8'h00, 8'h00,
    8'h00, mftp_pkg::SYSEX_START, 8'h00,
    8'h00, mftp_pkg::SYSEX_ESCAPE, 8'h00,
    8'h00, 8'h40,
    ST_NOTE_ON
  };
  localparam int DIR_B_LEN = 4;
  localparam logic [8*DIR_B_LEN-1:0] DIR_B = {8'h00, mftp_pkg::SYSEX_START, 8'h05, 8'hAA};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mftp_in_if  in_if ();
  mftp_out_if out_if ();

  midi_file_track_event_parser_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Stimulus and scoreboard storage.
  track_beat_t     pending_bytes [$];
  mftp_pkg::res_t  expected_events [$];
  logic [7:0]      track_buf [$];
  track_beat_t     next_beat;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned stall_requests;
  int unsigned stalls_served;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned bytes_queued;
  int unsigned tracks_queued;
  int unsigned bytes_accepted;
  int unsigned results_seen;
  int unsigned kind_seen [8];

  // Generator's view of running status inside the track being built.
  logic       gen_running;
  logic [7:0] gen_status;

  // Parser model state.
  mftp_pkg::phase_e parse_at;
  logic [31:0]      tick_sum;
  logic [7:0]       run_status;
  logic [7:0]       cur_status;
  logic [31:0]      vlq_acc;
  logic [31:0]      body_left;
  logic [7:0]       meta_type;
  logic [3:0]       meta_pos;
  logic [23:0]      tempo_acc;
  logic             loop_ok;
  logic [7:0]       held_data;
  logic             halted;

  // Clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    parse_at   = mftp_pkg::PH_DELTA;
    tick_sum   = '0;
    run_status = '0;
    cur_status = '0;
    vlq_acc    = '0;
    body_left  = '0;
    meta_type  = '0;
    meta_pos   = '0;
    tempo_acc  = '0;
    loop_ok    = 1'b1;
    held_data  = '0;
    halted     = 1'b0;
  endtask

  function automatic logic takes_one_data(logic [7:0] st);
    return (st[7:4] == mftp_pkg::HI_PROGRAM) || (st[7:4] == mftp_pkg::HI_PRESSURE);
  endfunction

  // A finished channel message goes back to waiting for a delta time.
  task automatic finish_channel(inout mftp_pkg::res_t ev, input logic [7:0] d1,
                                input logic [7:0] d2);
    ev.kind        = mftp_pkg::EV_CHANNEL;
    ev.status_byte = cur_status;
    ev.data_one    = d1;
    ev.data_two    = d2;
    parse_at       = mftp_pkg::PH_DELTA;
  endtask

  // Advance the model by one accepted byte and queue the result it causes.
  task automatic parse_track_byte(input logic [7:0] b, input logic last);
    mftp_pkg::res_t ev;
    logic [7:0]     st;
    logic           stray;
    ev    = '0;
    st    = '0;
    stray = 1'b0;
    if (!halted) begin
      case (parse_at)
        mftp_pkg::PH_DELTA: begin
          vlq_acc = {vlq_acc[24:0], b[6:0]};
          if (!b[7]) begin
            tick_sum = tick_sum + vlq_acc;
            vlq_acc  = '0;
            parse_at = mftp_pkg::PH_STATUS;
          end
        end
        mftp_pkg::PH_STATUS: begin
          if (b[7]) begin
            st = b;
          end else if (run_status[7]) begin
            st = run_status;
          end else begin
            // Data byte with no running status: ignore the rest of the track.
            halted = 1'b1;
            stray  = 1'b1;
          end
          if (stray) begin
          end else if (st == mftp_pkg::STATUS_META) begin
            parse_at = mftp_pkg::PH_META_TYPE;
          end else if (st == mftp_pkg::SYSEX_START || st == mftp_pkg::SYSEX_ESCAPE) begin
            cur_status = st;
            vlq_acc    = '0;
            parse_at   = mftp_pkg::PH_SYSEX_LEN;
          end else begin
            cur_status = st;
            run_status = st;
            if (b[7]) begin
              parse_at = mftp_pkg::PH_DATA1;
            end else if (takes_one_data(st)) begin
              finish_channel(ev, b, '0);
            end else begin
              held_data = b;
              parse_at  = mftp_pkg::PH_DATA2;
            end
          end
        end
        mftp_pkg::PH_DATA1: begin
          if (takes_one_data(cur_status)) begin
            finish_channel(ev, b, '0);
          end else begin
            held_data = b;
            parse_at  = mftp_pkg::PH_DATA2;
          end
        end
        mftp_pkg::PH_DATA2: begin
          finish_channel(ev, held_data, b);
        end
        mftp_pkg::PH_META_TYPE: begin
          meta_type = b;
          vlq_acc   = '0;
          parse_at  = mftp_pkg::PH_META_LEN;
        end
        mftp_pkg::PH_META_LEN: begin
          vlq_acc = {vlq_acc[24:0], b[6:0]};
          if (!b[7]) begin
            run_status = '0;
            body_left  = vlq_acc;
            vlq_acc    = '0;
            meta_pos   = '0;
            tempo_acc  = '0;
            loop_ok    = (body_left == mftp_pkg::LOOP_META_LEN);
            parse_at   = (body_left != 0) ? mftp_pkg::PH_META_BODY : mftp_pkg::PH_DELTA;
          end
        end
        mftp_pkg::PH_META_BODY: begin
          if (meta_type == mftp_pkg::META_TEMPO && meta_pos < mftp_pkg::TEMPO_BYTES) begin
            tempo_acc = {tempo_acc[15:0], b};
            if (meta_pos == mftp_pkg::TEMPO_LAST) begin
              ev.kind        = mftp_pkg::EV_TEMPO;
              ev.tempo_value = tempo_acc;
            end
          end else if (meta_type == mftp_pkg::META_MARKER &&
                       meta_pos < mftp_pkg::LOOP_NAME_LEN) begin
            if (b != LOOP_TEXT[8*(mftp_pkg::LOOP_LAST - meta_pos) +: 8]) loop_ok = 1'b0;
            if (meta_pos == mftp_pkg::LOOP_LAST && loop_ok) ev.kind = mftp_pkg::EV_LOOP_MARK;
          end
          if (meta_pos < mftp_pkg::META_IDX_MAX) meta_pos = meta_pos + 1'b1;
          body_left = body_left - 1;
          if (body_left == 0) parse_at = mftp_pkg::PH_DELTA;
        end
        mftp_pkg::PH_SYSEX_LEN: begin
          vlq_acc = {vlq_acc[24:0], b[6:0]};
          if (!b[7]) begin
            run_status = '0;
            body_left  = vlq_acc;
            vlq_acc    = '0;
            // Status 0xF0 is replayed as the first payload byte.
            if (cur_status == mftp_pkg::SYSEX_START) begin
              ev.kind       = mftp_pkg::EV_SYSEX_BYTE;
              ev.sysex_data = mftp_pkg::SYSEX_START;
              ev.sysex_last = (body_left == 0);
            end else if (body_left == 0) begin
              ev.kind = mftp_pkg::EV_SYSEX_EMPTY;
            end
            parse_at = (body_left != 0) ? mftp_pkg::PH_SYSEX_BODY : mftp_pkg::PH_DELTA;
          end
        end
        mftp_pkg::PH_SYSEX_BODY: begin
          ev.kind       = mftp_pkg::EV_SYSEX_BYTE;
          ev.sysex_data = b;
          ev.sysex_last = (body_left == 1);
          body_left     = body_left - 1;
          if (body_left == 0) parse_at = mftp_pkg::PH_DELTA;
        end
        default: begin
          parse_at = mftp_pkg::PH_DELTA;
        end
      endcase
    end

    ev.abs_tick = tick_sum;
    // The last byte of a track always yields a result and restarts the parser.
    if (last) begin
      ev.track_end = 1'b1;
      clear_parser();
    end
    if (ev.kind != mftp_pkg::EV_NONE || ev.track_end) expected_events.push_back(ev);
  endtask

  // ---------------------------------------------------------------------------
  // Track generation
  // ---------------------------------------------------------------------------

  task automatic add_vlq(input logic [31:0] val, input int unsigned pad);
    logic [7:0]  groups [$];
    logic [31:0] rest;
    rest = val;
    groups.push_front({1'b0, rest[6:0]});
    rest = rest >> 7;
    while (rest != 0) begin
      groups.push_front({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    // Leading continuation bytes with zero payload leave the value unchanged.
    repeat (pad) groups.push_front({1'b1, 7'd0});
    foreach (groups[i]) track_buf.push_back(groups[i]);
  endtask

  // Five-byte value with random bits; it overflows 32 bits and wraps.
  task automatic add_wide_vlq();
    repeat (4) track_buf.push_back({1'b1, 7'($urandom)});
    track_buf.push_back({1'b0, 7'($urandom)});
  endtask

  task automatic add_delta();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) add_vlq('0, 0);
    else if (pick < 85) add_vlq($urandom_range(127), 0);
    else if (pick < 95) add_vlq($urandom_range((1 << 21) - 1), $urandom_range(1));
    else add_wide_vlq();
  endtask

  task automatic add_data_byte();
    if ($urandom_range(19) == 0) track_buf.push_back(8'($urandom));
    else track_buf.push_back(8'($urandom_range(DATA_MAX)));
  endtask

  // One delta time followed by one event, mostly well formed.
  task automatic add_event();
    int unsigned pick;
    int unsigned len;
    int unsigned bad;
    logic [7:0]  st;
    logic [7:0]  c;
    pick = $urandom_range(99);
    add_delta();
    if (pick < 45) begin
      // Channel message, with running status about a third of the time.
      if (gen_running && $urandom_range(2) == 0) begin
        st = gen_status;
      end else begin
        if ($urandom_range(9) == 0) begin
          do st = 8'($urandom_range(SYS_HI, SYS_LO));
          while (st == mftp_pkg::SYSEX_ESCAPE);
        end else begin
          st = 8'($urandom_range(CHAN_HI, CHAN_LO));
        end
        track_buf.push_back(st);
        gen_status  = st;
        gen_running = 1'b1;
      end
      add_data_byte();
      if (!takes_one_data(st)) add_data_byte();
    end else if (pick < 55) begin
      // Tempo meta, sometimes short or long.
      len = ($urandom_range(4) == 0) ? $urandom_range(6) : 3;
      track_buf.push_back(mftp_pkg::STATUS_META);
      track_buf.push_back(mftp_pkg::META_TEMPO);
      add_vlq(len, ($urandom_range(9) == 0) ? 1 : 0);
      repeat (len) track_buf.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom));
      gen_running = 1'b0;
    end else if (pick < 63) begin
      // Loop marker: mostly exact, sometimes a flipped bit or a wrong length.
      len = mftp_pkg::LOOP_META_LEN;
      if ($urandom_range(6) == 0) len = ($urandom_range(1) != 0) ? 8 : 10;
      bad = ($urandom_range(5) == 0) ? $urandom_range(8) : 9;
      track_buf.push_back(mftp_pkg::STATUS_META);
      track_buf.push_back(mftp_pkg::META_MARKER);
      add_vlq(len, 0);
      for (int i = 0; i < len; i++) begin
        c = (i < 9) ? LOOP_TEXT[8*(8 - i) +: 8] : 8'($urandom);
        if (i == bad) c = c ^ 8'(1 << $urandom_range(7));
        track_buf.push_back(c);
      end
      gen_running = 1'b0;
    end else if (pick < 72) begin
      // Any other meta; long ones run the body index past its limit.
      track_buf.push_back(mftp_pkg::STATUS_META);
      track_buf.push_back(8'($urandom));
      if ($urandom_range(29) == 0) begin
        add_wide_vlq();
      end else begin
        len = $urandom_range(20);
        add_vlq(len, 0);
        repeat (len) track_buf.push_back(8'($urandom));
      end
      gen_running = 1'b0;
    end else if (pick < 97) begin
      // SysEx of either kind, often empty.
      track_buf.push_back(($urandom_range(1) != 0) ? mftp_pkg::SYSEX_START
                                                   : mftp_pkg::SYSEX_ESCAPE);
      len = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      add_vlq(len, ($urandom_range(9) == 0) ? 1 : 0);
      repeat (len) track_buf.push_back(8'($urandom));
      gen_running = 1'b0;
    end else begin
      // Lone data byte: stray unless running status is live.
      track_buf.push_back(8'($urandom_range(DATA_MAX)));
    end
  endtask

  // Move the built track to the driver queue, flagging its final byte.
  task automatic queue_track();
    for (int i = 0; i < track_buf.size(); i++) begin
      pending_bytes.push_back({track_buf[i], 1'(i == track_buf.size() - 1)});
    end
    bytes_queued  += track_buf.size();
    tracks_queued += 1;
  endtask

  task automatic load_directed(input logic [255:0] bytes, input int count);
    track_buf.delete();
    for (int i = count - 1; i >= 0; i--) track_buf.push_back(bytes[8*i +: 8]);
    queue_track();
  endtask

  task automatic build_track();
    int unsigned cut;
    track_buf.delete();
    gen_running = 1'b0;
    if ($urandom_range(11) == 0) begin
      // Raw noise.
      repeat ($urandom_range(12, 1)) track_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(10, 1)) add_event();
      // Sometimes the track ends in the middle of an event.
      if ($urandom_range(6) == 0) begin
        cut = $urandom_range(track_buf.size() - 1, 1);
        while (track_buf.size() > cut) void'(track_buf.pop_back());
      end
    end
    queue_track();
  endtask

  // Pause the sender until every queued byte is in and every result is out.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_if.valid || expected_events.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending byte, holding each beat until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.track_byte    <= '0;
      in_if.last_of_track <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_track_byte(in_if.track_byte, in_if.last_of_track);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_beat            = pending_bytes.pop_front();
          in_if.valid         <= 1'b1;
          in_if.track_byte    <= next_beat.value;
          in_if.last_of_track <= next_beat.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat and drives ready, with long holds.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    mftp_pkg::res_t want;
    results_seen++;
    kind_seen[out_if.event_kind]++;
    if (expected_events.size() == 0) begin
      $display("%0t ns: unexpected result, kind %0d tick 0x%0h track_end %0b",
               $time, out_if.event_kind, out_if.abs_tick, out_if.track_end);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      check_field("event_kind",  32'(want.kind),        32'(out_if.event_kind));
      check_field("abs_tick",    want.abs_tick,         out_if.abs_tick);
      check_field("status_byte", 32'(want.status_byte), 32'(out_if.status_byte));
      check_field("data_one",    32'(want.data_one),    32'(out_if.data_one));
      check_field("data_two",    32'(want.data_two),    32'(out_if.data_two));
      check_field("tempo_value", 32'(want.tempo_value), 32'(out_if.tempo_value));
      check_field("sysex_data",  32'(want.sysex_data),  32'(out_if.sysex_data));
      check_field("sysex_last",  32'(want.sysex_last),  32'(out_if.sysex_last));
      check_field("track_end",   32'(want.track_end),   32'(out_if.track_end));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready  <= 1'b0;
      hold_left     <= 0;
      stalls_served <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (stall_requests != stalls_served) begin
        stalls_served <= stall_requests;
        hold_left     <= HOLD_CYCLES;
        out_if.ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid         = 1'b0;
    in_if.track_byte    = '0;
    in_if.last_of_track = 1'b0;
    out_if.ready        = 1'b0;
    src_idle_pct        = 26;
    snk_idle_pct        = 78;
    stall_requests      = 0;
    mismatches          = 0;
    bytes_queued        = 0;
    tracks_queued       = 0;
    bytes_accepted      = 0;
    results_seen        = 0;
    gen_running         = 1'b0;
    gen_status          = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    clear_parser();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed tracks, then random tracks with a slow receiver.
    load_directed(DIR_A, DIR_A_LEN);
    load_directed(DIR_B, DIR_B_LEN);
    wait_for_drain();
    while (bytes_queued < 300) build_track();
    wait_for_drain();

    // Slow sender, eager receiver.
    src_idle_pct = 78;
    snk_idle_pct = 26;
    while (bytes_queued < 580) build_track();
    wait_for_drain();

    // No idling; a long receiver hold lets the result queue fill and stall input.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (bytes_queued < 860) build_track();
    stall_requests++;
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d bytes in %0d tracks; %0d results: channel %0d, sysex byte %0d,",
             bytes_accepted, tracks_queued, results_seen,
             kind_seen[mftp_pkg::EV_CHANNEL], kind_seen[mftp_pkg::EV_SYSEX_BYTE]);
    $display("empty sysex %0d, tempo %0d, loop marker %0d, bare track end %0d.",
             kind_seen[mftp_pkg::EV_SYSEX_EMPTY], kind_seen[mftp_pkg::EV_TEMPO],
             kind_seen[mftp_pkg::EV_LOOP_MARK], kind_seen[mftp_pkg::EV_NONE]);
    if (mismatches == 0) begin
      $display("midi_file_track_event_parser_unit: match");
    end else begin
      $display("midi_file_track_event_parser_unit: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected.", expected_events.size());
    $display("midi_file_track_event_parser_unit: mismatch");
    $finish;
  end

endmodule

[midi_file_track_event_parser_unit.f]
+incdir+hw/rtl
hw/rtl/mftp_pkg.sv
hw/rtl/mftp_if.sv
hw/rtl/mftp_front.sv
hw/rtl/mftp_queue.sv
hw/rtl/mftp_back.sv
hw/rtl/midi_file_track_event_parser_unit.sv
sim/tb.sv
